// ----- rtl/ctt_pkg.sv -----
// ============================================================================
// ctt_pkg : shared types and constants of the configuration text tokenizer
// Result kinds, error codes and the packed result batch that travels from
// the classifier to the output queue.
// ============================================================================
package ctt_pkg;

   localparam logic [2:0] KIND_TEXT  = 3'd0;
   localparam logic [2:0] KIND_SEND  = 3'd1;
   localparam logic [2:0] KIND_OPEN  = 3'd2;
   localparam logic [2:0] KIND_CLOSE = 3'd3;
   localparam logic [2:0] KIND_END   = 3'd4;
   localparam logic [2:0] KIND_ERROR = 3'd5;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_BAD_ESCAPE = 3'd1;
   localparam logic [2:0] ERR_NL_QUOTE   = 3'd2;
   localparam logic [2:0] ERR_END_QUOTE  = 3'd3;
   localparam logic [2:0] ERR_END_ESCAPE = 3'd4;

   localparam int TEXT_BITS = 16;
   localparam int MAX_ITEMS = 3;

   // One result as seen on the result ports.
   typedef struct packed {
      logic [2:0]           kind;
      logic [TEXT_BITS-1:0] text_char;
      logic [2:0]           error_code;
   } rsp_item_type;

   // All results that one request causes; count is 1 to MAX_ITEMS.
   typedef struct packed {
      logic [1:0]                    count;
      rsp_item_type [MAX_ITEMS-1:0]  item;
   } batch_type;

   // Handshake between classifier and output queue.
   typedef struct packed {
      logic push;
      logic full;
   } batch_ctl_type;

endpackage

// ----- rtl/config_text_tokenizer.sv -----
// ============================================================================
// config_text_tokenizer : streaming tokenizer for brace-structured config text
// Top level: request classifier followed by a batched result queue.
// ============================================================================
// The block takes one character per request and one request per clock cycle
// while full is low. Each request yields zero to three results (text
// character, string end, open or close brace, end, error); the results of a
// request are delivered in order, one per pop, and the last of them carries
// last high. A request is classified in the cycle it is accepted, so the
// scanner itself runs at one character per cycle while full is low; the
// result side drains one result per cycle while pop is high, and full
// rises when QUEUE_DEPTH requests with results are waiting.
// Requests that cause no result (whitespace, comments, the opening quote)
// never enter the queue. Only the low CHAR_BITS bits of a character count.
// After an error the block ignores characters until the end-of-input request,
// which flushes any open token, emits end and returns the scanner to reset.
// ============================================================================
module config_text_tokenizer #(
   parameter int CHAR_BITS   = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic [ctt_pkg::TEXT_BITS-1:0]    req_character,
   input  logic                             req_end_of_input,
   output logic                             empty,
   input  logic                             pop,
   output logic [2:0]                       rsp_kind,
   output logic [ctt_pkg::TEXT_BITS-1:0]    rsp_text_char,
   output logic [2:0]                       rsp_error_code,
   output logic                             rsp_last
);
   import ctt_pkg::*;

   logic          accept;
   logic          batch_valid;
   batch_type     batch;
   batch_ctl_type ctl;

   // A request is taken whenever the queue has room for its batch.
   assign full   = ctl.full;
   assign accept = push && !ctl.full;

   // The classifier updates the scanner mode and builds the result batch.
   ctt_front #(
      .CHAR_BITS (CHAR_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .character    (req_character),
      .end_of_input (req_end_of_input),
      .batch_valid  (batch_valid),
      .batch        (batch)
   );

   // The queue decouples the scanner from a stalled consumer.
   ctt_back #(
      .DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .batch      (batch),
      .batch_push (batch_valid),
      .ctl        (ctl),
      .pop        (pop),
      .empty      (empty),
      .kind       (rsp_kind),
      .text_char  (rsp_text_char),
      .error_code (rsp_error_code),
      .last       (rsp_last)
   );

endmodule

// ----- rtl/ctt_front.sv -----
// ============================================================================
// ctt_front : request classifier of the configuration text tokenizer
// Holds the scanner mode and turns each accepted request into a batch of up
// to three results in the same cycle as it is accepted.
// ============================================================================
module ctt_front #(
   parameter int CHAR_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [ctt_pkg::TEXT_BITS-1:0]    character,
   input  logic                             end_of_input,
   output logic                             batch_valid,
   output ctt_pkg::batch_type               batch
);
   import ctt_pkg::*;

   localparam int CW = (CHAR_BITS < TEXT_BITS) ? CHAR_BITS : TEXT_BITS;
   localparam logic [TEXT_BITS-1:0] CharMask =
      (CW == TEXT_BITS) ? {TEXT_BITS{1'b1}} : TEXT_BITS'((64'd1 << CW) - 64'd1);

   localparam logic [2:0] M_IDLE  = 3'd0;
   localparam logic [2:0] M_WORD  = 3'd1;
   localparam logic [2:0] M_QUOTE = 3'd2;
   localparam logic [2:0] M_ESC   = 3'd3;
   localparam logic [2:0] M_BAR   = 3'd4;
   localparam logic [2:0] M_LINE  = 3'd5;
   localparam logic [2:0] M_BLOCK = 3'd6;
   localparam logic [2:0] M_ERR   = 3'd7;

   localparam logic [TEXT_BITS-1:0] C_OPEN  = TEXT_BITS'(8'h7B);
   localparam logic [TEXT_BITS-1:0] C_CLOSE = TEXT_BITS'(8'h7D);
   localparam logic [TEXT_BITS-1:0] C_QUOTE = TEXT_BITS'(8'h22);
   localparam logic [TEXT_BITS-1:0] C_BAR   = TEXT_BITS'(8'h7C);
   localparam logic [TEXT_BITS-1:0] C_HASH  = TEXT_BITS'(8'h23);
   localparam logic [TEXT_BITS-1:0] C_BSL   = TEXT_BITS'(8'h5C);
   localparam logic [TEXT_BITS-1:0] C_N     = TEXT_BITS'(8'h6E);
   localparam logic [TEXT_BITS-1:0] C_T     = TEXT_BITS'(8'h74);
   localparam logic [TEXT_BITS-1:0] C_R     = TEXT_BITS'(8'h72);
   localparam logic [TEXT_BITS-1:0] C_TAB   = TEXT_BITS'(8'h09);
   localparam logic [TEXT_BITS-1:0] C_LF    = TEXT_BITS'(8'h0A);
   localparam logic [TEXT_BITS-1:0] C_CR    = TEXT_BITS'(8'h0D);
   localparam logic [TEXT_BITS-1:0] C_SP    = TEXT_BITS'(8'h20);

   logic [2:0] mode_ff, mode_in;
   logic       has_text_ff, has_text_in;
   logic       hash_ff, hash_in;

   logic [TEXT_BITS-1:0] c;
   logic                 is_ws, is_brace, is_newline;
   logic [2:0]           tag_kind;
   logic                 do_word;
   batch_type            b;

   // Appends one result to a batch.
   function automatic batch_type add_item(batch_type src, logic [2:0] kind,
                                          logic [TEXT_BITS-1:0] ch, logic [2:0] err);
      batch_type r;
      r = src;
      if (r.count != 2'(MAX_ITEMS)) begin
         r.item[r.count].kind       = kind;
         r.item[r.count].text_char  = ch;
         r.item[r.count].error_code = err;
         r.count                    = r.count + 2'd1;
      end
      return r;
   endfunction

   assign c          = character & CharMask;
   assign is_newline = (c == C_LF) || (c == C_CR);
   assign is_ws      = (c == C_SP) || (c == C_TAB) || is_newline;
   assign is_brace   = (c == C_OPEN) || (c == C_CLOSE);
   assign tag_kind   = (c == C_OPEN) ? KIND_OPEN : KIND_CLOSE;

   always_comb begin
      b           = '0;
      mode_in     = mode_ff;
      has_text_in = has_text_ff;
      hash_in     = hash_ff;
      do_word     = 1'b0;
      if (end_of_input) begin
         unique case (mode_ff)
            M_WORD:  b = add_item(b, KIND_SEND, '0, ERR_NONE);
            M_BAR: begin
               b = add_item(b, KIND_TEXT, C_BAR, ERR_NONE);
               b = add_item(b, KIND_SEND, '0, ERR_NONE);
            end
            M_QUOTE: b = add_item(b, KIND_ERROR, '0, ERR_END_QUOTE);
            M_ESC:   b = add_item(b, KIND_ERROR, '0, ERR_END_ESCAPE);
            default: ;
         endcase
         b           = add_item(b, KIND_END, '0, ERR_NONE);
         mode_in     = M_IDLE;
         has_text_in = 1'b0;
         hash_in     = 1'b0;
      end else begin
         unique case (mode_ff)
            M_IDLE: begin
               priority if (is_ws) begin
               end else if (c == C_QUOTE) begin
                  mode_in     = M_QUOTE;
                  has_text_in = 1'b0;
               end else if (is_brace) begin
                  b = add_item(b, tag_kind, '0, ERR_NONE);
               end else if (c == C_BAR) begin
                  mode_in     = M_BAR;
                  has_text_in = 1'b0;
               end else begin
                  b           = add_item(b, KIND_TEXT, c, ERR_NONE);
                  mode_in     = M_WORD;
                  has_text_in = 1'b1;
               end
            end
            M_WORD: do_word = 1'b1;
            M_QUOTE: begin
               priority if (c == C_QUOTE) begin
                  b           = add_item(b, KIND_SEND, '0, ERR_NONE);
                  mode_in     = M_IDLE;
                  has_text_in = 1'b0;
               end else if (c == C_BSL) begin
                  mode_in = M_ESC;
               end else if (is_brace && !has_text_ff) begin
                  // An empty quoted token drops its quote on a brace.
                  b       = add_item(b, tag_kind, '0, ERR_NONE);
                  mode_in = M_IDLE;
               end else if (is_newline) begin
                  b           = add_item(b, KIND_ERROR, '0, ERR_NL_QUOTE);
                  mode_in     = M_ERR;
                  has_text_in = 1'b0;
                  hash_in     = 1'b0;
               end else begin
                  b           = add_item(b, KIND_TEXT, c, ERR_NONE);
                  has_text_in = 1'b1;
               end
            end
            M_ESC: begin
               priority if (c == C_N || c == C_T || c == C_R || c == C_QUOTE
                            || c == C_BSL) begin
                  b = add_item(b, KIND_TEXT,
                               (c == C_N) ? C_LF : (c == C_T) ? C_TAB :
                               (c == C_R) ? C_CR : c, ERR_NONE);
                  has_text_in = 1'b1;
                  mode_in     = M_QUOTE;
               end else begin
                  b           = add_item(b, KIND_ERROR, '0, ERR_BAD_ESCAPE);
                  mode_in     = M_ERR;
                  has_text_in = 1'b0;
                  hash_in     = 1'b0;
               end
            end
            M_BAR: begin
               if (c == C_BAR || c == C_HASH) begin
                  if (has_text_ff) begin
                     b = add_item(b, KIND_SEND, '0, ERR_NONE);
                  end
                  has_text_in = 1'b0;
                  hash_in     = 1'b0;
                  mode_in     = (c == C_BAR) ? M_LINE : M_BLOCK;
               end else begin
                  // A lone bar is text; the character is then handled as inside a word.
                  b       = add_item(b, KIND_TEXT, C_BAR, ERR_NONE);
                  do_word = 1'b1;
               end
            end
            M_LINE: begin
               if (is_newline) begin
                  mode_in = M_IDLE;
               end
            end
            M_BLOCK: begin
               if (hash_ff && c == C_BAR) begin
                  mode_in = M_IDLE;
                  hash_in = 1'b0;
               end else begin
                  hash_in = (c == C_HASH);
               end
            end
            default: ;
         endcase

         if (do_word) begin
            priority if (c == C_QUOTE) begin
               b           = add_item(b, KIND_SEND, '0, ERR_NONE);
               mode_in     = M_QUOTE;
               has_text_in = 1'b0;
            end else if (is_brace) begin
               b           = add_item(b, KIND_SEND, '0, ERR_NONE);
               b           = add_item(b, tag_kind, '0, ERR_NONE);
               mode_in     = M_IDLE;
               has_text_in = 1'b0;
            end else if (is_ws) begin
               b           = add_item(b, KIND_SEND, '0, ERR_NONE);
               mode_in     = M_IDLE;
               has_text_in = 1'b0;
            end else if (c == C_BAR) begin
               mode_in     = M_BAR;
               has_text_in = 1'b1;
            end else begin
               b           = add_item(b, KIND_TEXT, c, ERR_NONE);
               mode_in     = M_WORD;
               has_text_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= M_IDLE;
         has_text_ff <= 1'b0;
         hash_ff     <= 1'b0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         has_text_ff <= has_text_in;
         hash_ff     <= hash_in;
      end
   end

   assign batch       = b;
   assign batch_valid = accept && (b.count != 2'd0);

endmodule

// ----- rtl/ctt_back.sv -----
// ============================================================================
// ctt_back : result queue of the configuration text tokenizer
// Stores result batches and hands them out one result per pop.
// ============================================================================
module ctt_back #(
   parameter int DEPTH = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ctt_pkg::batch_type               batch,
   input  logic                             batch_push,
   output ctt_pkg::batch_ctl_type           ctl,
   input  logic                             pop,
   output logic                             empty,
   output logic [2:0]                       kind,
   output logic [ctt_pkg::TEXT_BITS-1:0]    text_char,
   output logic [2:0]                       error_code,
   output logic                             last
);
   import ctt_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   batch_type         entry_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]   count_ff, count_in;
   logic [1:0]        sub_ff, sub_in;

   batch_type         head;
   rsp_item_type      head_item;
   logic              do_push, do_pop, head_done;

   assign head      = entry_ff[rd_ptr_ff];
   assign head_item = head.item[sub_ff];
   assign empty     = (count_ff == '0);
   assign ctl.full  = (count_ff == CNTW'(DEPTH));
   assign ctl.push  = batch_push;
   assign last      = (sub_ff == head.count - 2'd1);

   assign kind       = head_item.kind;
   assign text_char  = head_item.text_char;
   assign error_code = head_item.error_code;

   assign do_push   = batch_push && !ctl.full;
   assign do_pop    = pop && !empty;
   assign head_done = do_pop && last;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      sub_in    = sub_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         sub_in = sub_ff + 2'd1;
      end
      if (head_done) begin
         sub_in    = '0;
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !head_done) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && head_done) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sub_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sub_ff    <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= batch;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(DEPTH))
      else $error("queue count exceeds depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      ctl.full |-> !batch_push)
      else $error("batch pushed into a full queue");

   a_sub_in_batch: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (sub_ff < head.count))
      else $error("result index beyond head batch");

   a_retire: assert property (@(posedge clock) disable iff (reset)
      (head_done && !do_push) |=> (count_ff == $past(count_ff) - 1'b1) && (sub_ff == '0))
      else $error("finished batch not retired");

endmodule

// ----- tb/tb_config_text_tokenizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_config_text_tokenizer : self-checking bench for the text tokenizer
// Streams characters into the tokenizer through its request port and pops
// the results at random. A mirror of the scanner, kept in step with every
// accepted request, predicts the tokens, and each popped result is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
package tb_ctt_pkg;
   import ctt_pkg::*;

   localparam logic [TEXT_BITS-1:0] CH_OPEN  = 16'h007B;
   localparam logic [TEXT_BITS-1:0] CH_CLOSE = 16'h007D;
   localparam logic [TEXT_BITS-1:0] CH_QUOTE = 16'h0022;
   localparam logic [TEXT_BITS-1:0] CH_BAR   = 16'h007C;
   localparam logic [TEXT_BITS-1:0] CH_HASH  = 16'h0023;
   localparam logic [TEXT_BITS-1:0] CH_BSL   = 16'h005C;
   localparam logic [TEXT_BITS-1:0] CH_N     = 16'h006E;
   localparam logic [TEXT_BITS-1:0] CH_T     = 16'h0074;
   localparam logic [TEXT_BITS-1:0] CH_R     = 16'h0072;
   localparam logic [TEXT_BITS-1:0] CH_TAB   = 16'h0009;
   localparam logic [TEXT_BITS-1:0] CH_LF    = 16'h000A;
   localparam logic [TEXT_BITS-1:0] CH_CR    = 16'h000D;
   localparam logic [TEXT_BITS-1:0] CH_SPACE = 16'h0020;
   localparam logic [TEXT_BITS-1:0] CH_A     = 16'h0061;
   localparam logic [TEXT_BITS-1:0] CH_Z     = 16'h007A;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_WORD, SCAN_QUOTE, SCAN_ESCAPE,
      SCAN_BAR, SCAN_LINE, SCAN_BLOCK, SCAN_ERROR
   } scan_mode_type;

   typedef struct packed {
      logic [2:0]           kind;
      logic [TEXT_BITS-1:0] text_char;
      logic [2:0]           error_code;
      logic                 last;
   } token_type;

   function automatic bit is_blank(logic [TEXT_BITS-1:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
   endfunction

   function automatic bit is_brace(logic [TEXT_BITS-1:0] c);
      return c == CH_OPEN || c == CH_CLOSE;
   endfunction

   function automatic logic [2:0] brace_kind(logic [TEXT_BITS-1:0] c);
      return (c == CH_OPEN) ? KIND_OPEN : KIND_CLOSE;
   endfunction

   // Mirror of the scanner plus the tokens it has predicted but not yet seen.
   class tokenizer_mirror;
      scan_mode_type mode;
      bit            has_text;
      bit            hash_seen;
      int            mistakes;
      token_type     step_tokens[$];
      token_type     pending_tokens[$];

      function new();
         mode      = SCAN_IDLE;
         has_text  = 1'b0;
         hash_seen = 1'b0;
         mistakes  = 0;
      endfunction

      function void emit(logic [2:0] kind, logic [TEXT_BITS-1:0] ch = '0,
                         logic [2:0] err = ERR_NONE);
         token_type t;
         t.kind       = kind;
         t.text_char  = ch;
         t.error_code = err;
         t.last       = 1'b0;
         step_tokens.push_back(t);
      endfunction

      function void raise_error(logic [2:0] code);
         emit(KIND_ERROR, '0, code);
         mode      = SCAN_ERROR;
         has_text  = 1'b0;
         hash_seen = 1'b0;
      endfunction

      // A character inside an unquoted token that already holds text.
      function void word_char(logic [TEXT_BITS-1:0] c);
         if (c == CH_QUOTE) begin
            emit(KIND_SEND);
            mode     = SCAN_QUOTE;
            has_text = 1'b0;
         end else if (is_brace(c)) begin
            emit(KIND_SEND);
            emit(brace_kind(c));
            mode     = SCAN_IDLE;
            has_text = 1'b0;
         end else if (is_blank(c)) begin
            emit(KIND_SEND);
            mode     = SCAN_IDLE;
            has_text = 1'b0;
         end else if (c == CH_BAR) begin
            mode = SCAN_BAR;
         end else begin
            emit(KIND_TEXT, c);
            mode     = SCAN_WORD;
            has_text = 1'b1;
         end
      endfunction

      function void take_character(logic [TEXT_BITS-1:0] c, logic eoi);
         logic [TEXT_BITS-1:0] translated;
         bit                   known;
         step_tokens.delete();
         if (eoi) begin
            case (mode)
               SCAN_WORD: emit(KIND_SEND);
               SCAN_BAR: begin
                  emit(KIND_TEXT, CH_BAR);
                  emit(KIND_SEND);
               end
               SCAN_QUOTE:  emit(KIND_ERROR, '0, ERR_END_QUOTE);
               SCAN_ESCAPE: emit(KIND_ERROR, '0, ERR_END_ESCAPE);
               default: ;
            endcase
            emit(KIND_END);
            mode      = SCAN_IDLE;
            has_text  = 1'b0;
            hash_seen = 1'b0;
         end else begin
            case (mode)
               SCAN_IDLE: begin
                  if (is_blank(c)) begin
                  end else if (c == CH_QUOTE) begin
                     mode     = SCAN_QUOTE;
                     has_text = 1'b0;
                  end else if (is_brace(c)) begin
                     emit(brace_kind(c));
                  end else if (c == CH_BAR) begin
                     mode     = SCAN_BAR;
                     has_text = 1'b0;
                  end else begin
                     emit(KIND_TEXT, c);
                     mode     = SCAN_WORD;
                     has_text = 1'b1;
                  end
               end
               SCAN_WORD: word_char(c);
               SCAN_QUOTE: begin
                  if (c == CH_QUOTE) begin
                     emit(KIND_SEND);
                     mode     = SCAN_IDLE;
                     has_text = 1'b0;
                  end else if (c == CH_BSL) begin
                     mode = SCAN_ESCAPE;
                  end else if (is_brace(c) && !has_text) begin
                     emit(brace_kind(c));
                     mode = SCAN_IDLE;
                  end else if (c == CH_LF || c == CH_CR) begin
                     raise_error(ERR_NL_QUOTE);
                  end else begin
                     emit(KIND_TEXT, c);
                     has_text = 1'b1;
                  end
               end
               SCAN_ESCAPE: begin
                  known      = 1'b1;
                  translated = c;
                  case (c)
                     CH_N: translated = CH_LF;
                     CH_T: translated = CH_TAB;
                     CH_R: translated = CH_CR;
                     CH_QUOTE, CH_BSL: translated = c;
                     default: known = 1'b0;
                  endcase
                  if (!known) begin
                     raise_error(ERR_BAD_ESCAPE);
                  end else begin
                     emit(KIND_TEXT, translated);
                     has_text = 1'b1;
                     mode     = SCAN_QUOTE;
                  end
               end
               SCAN_BAR: begin
                  if (c == CH_BAR || c == CH_HASH) begin
                     if (has_text) emit(KIND_SEND);
                     has_text  = 1'b0;
                     hash_seen = 1'b0;
                     if (c == CH_BAR) mode = SCAN_LINE;
                     else mode = SCAN_BLOCK;
                  end else begin
                     emit(KIND_TEXT, CH_BAR);
                     has_text = 1'b1;
                     mode     = SCAN_WORD;
                     word_char(c);
                  end
               end
               SCAN_LINE: begin
                  if (c == CH_LF || c == CH_CR) mode = SCAN_IDLE;
               end
               SCAN_BLOCK: begin
                  if (hash_seen && c == CH_BAR) begin
                     mode      = SCAN_IDLE;
                     hash_seen = 1'b0;
                  end else begin
                     hash_seen = (c == CH_HASH);
                  end
               end
               default: ;
            endcase
         end
         if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
         foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
      endfunction

      function void compare_field(string field, logic [TEXT_BITS-1:0] want,
                                  logic [TEXT_BITS-1:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mistakes++;
         end
      endfunction

      function void match_token(logic [2:0] kind, logic [TEXT_BITS-1:0] text,
                                logic [2:0] err, logic last);
         token_type want;
         if (pending_tokens.size() == 0) begin
            $display("%0t: result with none expected, actual kind %0h text %0h error %0h last %b",
                     $time, kind, text, err, last);
            mistakes++;
            return;
         end
         want = pending_tokens.pop_front();
         compare_field("kind", TEXT_BITS'(want.kind), TEXT_BITS'(kind));
         compare_field("text_char", want.text_char, text);
         compare_field("error_code", TEXT_BITS'(want.error_code), TEXT_BITS'(err));
         compare_field("last", TEXT_BITS'(want.last), TEXT_BITS'(last));
      endfunction
   endclass

endpackage

// ----------------------------------------------------------------------------
// tb_config_text_tokenizer : top level of the tokenizer bench
// Directed text covering the corner cases of the scanner, then random text
// built mostly from well-formed tokens, quoted strings, braces and comments,
// with noise mixed in. Both queue sides idle at random.
// ----------------------------------------------------------------------------
module tb_config_text_tokenizer;
   import ctt_pkg::*;
   import tb_ctt_pkg::*;

   localparam int RANDOM_ITEMS = 270;
   // Cycles without any accepted request or result before the run is abandoned.
   // The slowest correct run never comes near this: a request holds the result
   // port for at most three pops.
   localparam int STALL_LIMIT  = 1000;
   // The result queue is four batches deep, so DRAIN_CYCLES of quiet at
   // the end are ample for any stray result to show itself.
   localparam int DRAIN_CYCLES = 16;

   localparam logic [TEXT_BITS-1:0] ESCAPE_LETTERS[5] = '{CH_N, CH_T, CH_R, CH_QUOTE, CH_BSL};
   localparam logic [TEXT_BITS-1:0] NOISE[10] = '{CH_OPEN, CH_CLOSE, CH_QUOTE, CH_BAR,
                                                   CH_HASH, CH_BSL, CH_SPACE, CH_TAB,
                                                   CH_LF, CH_CR};

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 push             = 1'b0;
   logic                 full;
   logic [TEXT_BITS-1:0] req_character    = '0;
   logic                 req_end_of_input = 1'b0;
   logic                 empty;
   logic                 pop              = 1'b0;
   logic [2:0]           rsp_kind;
   logic [TEXT_BITS-1:0] rsp_text_char;
   logic [2:0]           rsp_error_code;
   logic                 rsp_last;

   tokenizer_mirror mirror;
   // While steady is set neither side idles, so the queue runs flat out.
   bit              steady      = 1'b0;
   int              counted     = 0;
   int              idle_cycles = 0;

   config_text_tokenizer #(.CHAR_BITS(16)) DUT (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_character    (req_character),
      .req_end_of_input (req_end_of_input),
      .empty            (empty),
      .pop              (pop),
      .rsp_kind         (rsp_kind),
      .rsp_text_char    (rsp_text_char),
      .rsp_error_code   (rsp_error_code),
      .rsp_last         (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Offers one request and returns at the edge where it is taken. Inputs
   // change only by nonblocking assignment just after an edge, and full is
   // read straight after the edge, so it is the value the block acted on.
   task automatic send_request(input logic [TEXT_BITS-1:0] c, input logic eoi);
      while (!steady && $urandom_range(99) < 13) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push             <= 1'b1;
      req_character    <= c;
      req_end_of_input <= eoi;
      @(posedge clock);
      while (full) @(posedge clock);
      counted++;
      mirror.take_character(c, eoi);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_request(TEXT_BITS'(s[i]), 1'b0);
   endtask

   // The character that travels with the end marker is meant to be ignored,
   // so it carries random bits.
   task automatic end_of_text();
      send_request(TEXT_BITS'($urandom_range(16'hFFFF)), 1'b1);
   endtask

   function automatic bit breaks_word(logic [TEXT_BITS-1:0] c);
      return is_blank(c) || is_brace(c) || c == CH_QUOTE || c == CH_BAR;
   endfunction

   // A plain token character: half lower-case letters, half full-width codes,
   // so that every bit of the character port is exercised both ways.
   function automatic logic [TEXT_BITS-1:0] word_letter();
      logic [TEXT_BITS-1:0] c;
      if ($urandom_range(1) == 0) c = TEXT_BITS'($urandom_range(CH_Z, CH_A));
      else c = TEXT_BITS'($urandom_range(16'hFFFF));
      if (breaks_word(c)) c = CH_N;
      return c;
   endfunction

   function automatic logic [TEXT_BITS-1:0] any_brace();
      return ($urandom_range(1) == 0) ? CH_OPEN : CH_CLOSE;
   endfunction

   // Result side: a result is taken at an edge where pop was high and empty
   // low, and the ports are sampled at that same edge.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) mirror.match_token(rsp_kind, rsp_text_char, rsp_error_code, rsp_last);
         pop <= steady || ($urandom_range(99) >= 13);
      end
   end

   // Watchdog: any accepted request or result clears the count.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL config_text_tokenizer");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      mirror = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A word cut short by a quote, and a brace in the still empty quote,
      // which gives a tag and drops the quote.
      send_text("a\"{");
      // Widest character as a word, closed by a brace: string end, then tag.
      send_request(16'hFFFF, 1'b0);
      send_text("}");
      // Quoted string holding the zero character, a brace as text, an escape.
      send_request(CH_QUOTE, 1'b0);
      send_request(16'h0000, 1'b0);
      send_text("{\\n\"");
      // Single bar turns into text; a comment opened inside the token then
      // closes it on its second bar; the line feed ends the comment.
      send_text("|b||\n");
      // The hash of the opener must not pair with the following bar.
      send_text("|#|#|");
      // End of text with a bar pending after text, after a backslash, and
      // inside an open quote.
      send_text("z|");
      end_of_text();
      send_text("\"\\");
      end_of_text();
      send_text("\"");
      end_of_text();
      // Bad escape, then a character that the error mode must ignore.
      send_text("\"\\qx");
      end_of_text();
      // Line feed inside a quote.
      send_text("\"\n");
      end_of_text();

      // Random text. Each pass through the loop writes one phrase; roughly a
      // twentieth of the phrases end the text, which also clears sticky errors.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         steady <= (counted >= 100 && counted < 180);
         case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 19: begin
               repeat ($urandom_range(5, 1)) send_request(word_letter(), 1'b0);
               case ($urandom_range(7))
                  0: send_request(CH_SPACE, 1'b0);
                  1: send_request(CH_TAB, 1'b0);
                  2: send_request(($urandom_range(1) == 0) ? CH_LF : CH_CR, 1'b0);
                  3: send_request(any_brace(), 1'b0);
                  4: send_request(CH_QUOTE, 1'b0);
                  5: begin
                     send_request(CH_BAR, 1'b0);
                     send_request(word_letter(), 1'b0);
                  end
                  6: send_request(CH_BAR, 1'b0);
                  default: ;
               endcase
            end
            6, 7, 8, 9: begin
               send_request(CH_QUOTE, 1'b0);
               if ($urandom_range(9) == 0) begin
                  send_request(any_brace(), 1'b0);
               end else begin
                  repeat ($urandom_range(5)) begin
                     case ($urandom_range(9))
                        0, 1: begin
                           send_request(CH_BSL, 1'b0);
                           if ($urandom_range(9) == 0) send_request(word_letter(), 1'b0);
                           else send_request(ESCAPE_LETTERS[$urandom_range(4)], 1'b0);
                        end
                        2: send_request(NOISE[$urandom_range(7)], 1'b0);
                        default: send_request(word_letter(), 1'b0);
                     endcase
                  end
                  if ($urandom_range(11) != 0) send_request(CH_QUOTE, 1'b0);
               end
            end
            10, 11: send_request(any_brace(), 1'b0);
            12: begin
               send_text("||");
               repeat ($urandom_range(3)) send_request(word_letter(), 1'b0);
               send_request(($urandom_range(1) == 0) ? CH_LF : CH_CR, 1'b0);
            end
            13: begin
               send_text("|#");
               repeat ($urandom_range(4)) begin
                  case ($urandom_range(2))
                     0: send_request(CH_HASH, 1'b0);
                     1: send_request(CH_BAR, 1'b0);
                     default: send_request(word_letter(), 1'b0);
                  endcase
               end
               send_text("#|");
            end
            14, 15: repeat ($urandom_range(3, 1)) send_request(NOISE[$urandom_range(9, 6)], 1'b0);
            16, 17: begin
               if ($urandom_range(1) == 0) send_request(TEXT_BITS'($urandom_range(16'hFFFF)), 1'b0);
               else send_request(NOISE[$urandom_range(9)], 1'b0);
            end
            default: end_of_text();
         endcase
      end
      end_of_text();
      push   <= 1'b0;
      steady <= 1'b0;

      // Let every predicted token arrive, then watch a little longer for
      // anything the block should not have produced.
      while (mirror.pending_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mirror.mistakes == 0) begin
         $display("PASS config_text_tokenizer");
      end else begin
         $display("FAIL config_text_tokenizer");
      end
      $finish;
   end

endmodule
